// File: hw/rtl/speq_pkg.sv
// Shared package for the sorted priority event queue.
// Holds sizing constants, the controller state type and the command struct.
// No dependencies.
package speq_pkg;

    localparam int CAPACITY = 16;
    localparam int KEY_BITS = 32;
    localparam int TAG_BITS = 16;
    localparam int CNT_BITS = $clog2(CAPACITY + 1);

    localparam logic MODE_ENQUEUE = 1'b0;
    localparam logic MODE_DEQUEUE = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_RESULT
    } ctl_state_t;

    typedef struct packed {
        logic exec;
    } dp_cmd_t;

endpackage

// File: hw/rtl/speq_ctrl.sv
// Handshake controller for the sorted priority event queue.
// Tracks whether a result item is held and issues the execute command.
// Depends on speq_pkg.
module speq_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output speq_pkg::dp_cmd_t cmd
);

    speq_pkg::ctl_state_t state_reg;
    speq_pkg::ctl_state_t state_next;
    logic                 accept;

    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= speq_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            speq_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = speq_pkg::ST_RESULT;
                end
            end
            speq_pkg::ST_RESULT: begin
                if (m_ready && !accept) begin
                    state_next = speq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = speq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready  = 1'b0;
        m_valid  = 1'b0;
        case (state_reg)
            speq_pkg::ST_IDLE: begin
                s_ready = 1'b1;
            end
            speq_pkg::ST_RESULT: begin
                s_ready = m_ready;
                m_valid = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
        cmd.exec = s_valid && s_ready;
    end

endmodule

// File: hw/rtl/speq_datapath.sv
// Datapath of the sorted priority event queue: a sorted row of key/tag slots
// with per-slot compare and shift, the entry count and the result register.
// Depends on speq_pkg.
module speq_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  speq_pkg::dp_cmd_t                 cmd,
    input  logic                              mode,
    input  logic [speq_pkg::KEY_BITS-1:0]     key_in,
    input  logic [speq_pkg::TAG_BITS-1:0]     tag_in,
    output logic                              head_valid,
    output logic [speq_pkg::KEY_BITS-1:0]     key_out,
    output logic [speq_pkg::TAG_BITS-1:0]     tag_out,
    output logic [speq_pkg::CNT_BITS-1:0]     occupancy,
    output logic                              dropped
);

    localparam int CAP = speq_pkg::CAPACITY;
    localparam int CW  = speq_pkg::CNT_BITS;

    logic [speq_pkg::KEY_BITS-1:0] key_reg [CAP];
    logic [speq_pkg::TAG_BITS-1:0] tag_reg [CAP];
    logic [speq_pkg::KEY_BITS-1:0] key_next [CAP];
    logic [speq_pkg::TAG_BITS-1:0] tag_next [CAP];
    logic [CW-1:0]                 count_reg;
    logic [CW-1:0]                 count_next;

    logic                          hv_reg,  hv_next;
    logic [speq_pkg::KEY_BITS-1:0] kout_reg, kout_next;
    logic [speq_pkg::TAG_BITS-1:0] tout_reg, tout_next;
    logic [CW-1:0]                 occ_reg, occ_next;
    logic                          drop_reg, drop_next;

    logic                          lead;
    logic                          full;
    logic                          empty;
    logic                          do_enq;
    logic                          do_deq;
    logic [CAP-1:0]                slot_valid;
    logic [CAP-1:0]                shift;
    logic [CAP-1:0]                ins;

    assign lead   = key_in <= key_reg[0];
    assign full   = count_reg == CW'(CAP);
    assign empty  = count_reg == '0;
    assign do_enq = cmd.exec && (mode == speq_pkg::MODE_ENQUEUE) && !full;
    assign do_deq = cmd.exec && (mode == speq_pkg::MODE_DEQUEUE) && !empty;

    for (genvar g = 0; g < CAP; g++) begin : g_slot
        assign slot_valid[g] = CW'(g) < count_reg;
        assign shift[g]      = slot_valid[g] && (lead || (key_in < key_reg[g]));

        if (g == 0) begin : g_head
            assign ins[g] = empty || lead;
            always_comb begin
                key_next[g] = key_reg[g];
                tag_next[g] = tag_reg[g];
                if (do_enq && ins[g]) begin
                    key_next[g] = key_in;
                    tag_next[g] = tag_in;
                end else if (do_deq) begin
                    key_next[g] = key_reg[g+1];
                    tag_next[g] = tag_reg[g+1];
                end
            end
        end else begin : g_body
            assign ins[g] = !shift[g-1] && (shift[g] || (CW'(g) == count_reg));
            always_comb begin
                key_next[g] = key_reg[g];
                tag_next[g] = tag_reg[g];
                if (do_enq) begin
                    if (ins[g]) begin
                        key_next[g] = key_in;
                        tag_next[g] = tag_in;
                    end else if (shift[g-1]) begin
                        key_next[g] = key_reg[g-1];
                        tag_next[g] = tag_reg[g-1];
                    end
                end else if (do_deq && (g < CAP - 1)) begin
                    key_next[g] = key_reg[(g < CAP - 1) ? g + 1 : g];
                    tag_next[g] = tag_reg[(g < CAP - 1) ? g + 1 : g];
                end
            end
        end
    end

    always_comb begin
        count_next = count_reg;
        hv_next    = hv_reg;
        kout_next  = kout_reg;
        tout_next  = tout_reg;
        occ_next   = occ_reg;
        drop_next  = drop_reg;
        if (cmd.exec) begin
            hv_next   = 1'b0;
            kout_next = '0;
            tout_next = '0;
            drop_next = 1'b0;
            if (mode == speq_pkg::MODE_ENQUEUE) begin
                if (full) begin
                    drop_next = 1'b1;
                end else begin
                    count_next = count_reg + 1'b1;
                end
            end else if (!empty) begin
                hv_next    = 1'b1;
                kout_next  = key_reg[0];
                tout_next  = tag_reg[0];
                count_next = count_reg - 1'b1;
            end
            occ_next = count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < CAP; i++) begin
            key_reg[i] <= key_next[i];
            tag_reg[i] <= tag_next[i];
        end
        hv_reg   <= hv_next;
        kout_reg <= kout_next;
        tout_reg <= tout_next;
        occ_reg  <= occ_next;
        drop_reg <= drop_next;
    end

    assign head_valid = hv_reg;
    assign key_out    = kout_reg;
    assign tag_out    = tout_reg;
    assign occupancy  = occ_reg;
    assign dropped    = drop_reg;

endmodule

// File: hw/rtl/sorted_priority_event_queue_core.sv
// Top level of the sorted priority event queue.
// Instantiates speq_ctrl and speq_datapath; depends on speq_pkg.
//
//  Channel  | Direction | Handshake          | Item fields
//  s_       | in        | s_valid / s_ready  | mode, key_in, tag_in
//  m_       | out       | m_valid / m_ready  | head_valid, key_out, tag_out,
//           |           |                    | occupancy, dropped
//
// The slot row compares and shifts all entries in the cycle an item is accepted,
// and the result appears in the output register on the next cycle. While that
// result is held, a new item is taken in the same cycle the result is taken.
// Reset empties the queue by clearing the entry count.
module sorted_priority_event_queue_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_mode,
    input  logic [speq_pkg::KEY_BITS-1:0] s_key_in,
    input  logic [speq_pkg::TAG_BITS-1:0] s_tag_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_head_valid,
    output logic [speq_pkg::KEY_BITS-1:0] m_key_out,
    output logic [speq_pkg::TAG_BITS-1:0] m_tag_out,
    output logic [speq_pkg::CNT_BITS-1:0] m_occupancy,
    output logic                          m_dropped
);

    speq_pkg::dp_cmd_t cmd;

    speq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    speq_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .mode       (s_mode),
        .key_in     (s_key_in),
        .tag_in     (s_tag_in),
        .head_valid (m_head_valid),
        .key_out    (m_key_out),
        .tag_out    (m_tag_out),
        .occupancy  (m_occupancy),
        .dropped    (m_dropped)
    );

endmodule

// File: hw/rtl/speq_checker.sv
// Port-level checker for the sorted priority event queue, with its bind.
// Depends on speq_pkg and sorted_priority_event_queue_core.
module speq_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic                          m_head_valid,
    input logic [speq_pkg::KEY_BITS-1:0] m_key_out,
    input logic [speq_pkg::CNT_BITS-1:0] m_occupancy,
    input logic                          m_dropped
);

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> m_valid)
        else $error("An accepted item gave no result on the next cycle.");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_key_out)))
        else $error("A stalled result item changed.");

    a_drop_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_dropped) |->
            (!m_head_valid && (m_occupancy == speq_pkg::CNT_BITS'(speq_pkg::CAPACITY))))
        else $error("A dropped item did not report a full queue.");

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_occupancy <= speq_pkg::CNT_BITS'(speq_pkg::CAPACITY)))
        else $error("Occupancy exceeds the capacity.");

endmodule

bind sorted_priority_event_queue_core speq_checker u_speq_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_head_valid (m_head_valid),
    .m_key_out    (m_key_out),
    .m_occupancy  (m_occupancy),
    .m_dropped    (m_dropped)
);

// File: dv/sorted_priority_event_queue_core_tb.sv
// Self-checking testbench for sorted_priority_event_queue_core: drives directed and
// random enqueue and dequeue items and checks every result against a sorted-queue
// predictor kept in a class. Depends on speq_pkg and the RTL of the core only.
module sorted_priority_event_queue_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1130;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int REPORT_LIMIT = 40;

    typedef enum int {
        FILL_BIAS,
        DRAIN_BIAS,
        MIXED_OPS
    } phase_kind_t;

    typedef struct packed {
        logic                          head_valid;
        logic [speq_pkg::KEY_BITS-1:0] key;
        logic [speq_pkg::TAG_BITS-1:0] tag;
        logic [speq_pkg::CNT_BITS-1:0] occupancy;
        logic                          dropped;
    } queue_outcome_t;

    class queue_order_tracker;
        logic [speq_pkg::KEY_BITS-1:0] held_keys[$];
        logic [speq_pkg::TAG_BITS-1:0] held_tags[$];
        queue_outcome_t                pending_outcomes[$];
        int mismatches = 0;
        int checked    = 0;
        int pushes     = 0;
        int refused    = 0;
        int pops       = 0;
        int empty_pops = 0;
        int peak       = 0;

        function void note_operation(logic mode, logic [speq_pkg::KEY_BITS-1:0] key,
                                     logic [speq_pkg::TAG_BITS-1:0] tag);
            queue_outcome_t o;
            int pos;
            o = '0;
            if (mode == speq_pkg::MODE_ENQUEUE) begin
                pushes++;
                if (held_keys.size() >= speq_pkg::CAPACITY) begin
                    o.dropped = 1'b1;
                    refused++;
                end else begin
                    pos = held_keys.size();
                    if (held_keys.size() == 0 || key <= held_keys[0]) begin
                        pos = 0;
                    end else begin
                        // Equal keys behind the head keep their arrival order.
                        for (int i = held_keys.size() - 1; i >= 1; i--) begin
                            if (key < held_keys[i]) pos = i;
                        end
                    end
                    held_keys.insert(pos, key);
                    held_tags.insert(pos, tag);
                end
            end else begin
                pops++;
                if (held_keys.size() == 0) begin
                    empty_pops++;
                end else begin
                    o.head_valid = 1'b1;
                    o.key        = held_keys.pop_front();
                    o.tag        = held_tags.pop_front();
                end
            end
            o.occupancy = speq_pkg::CNT_BITS'(held_keys.size());
            if (held_keys.size() > peak) peak = held_keys.size();
            pending_outcomes.push_back(o);
        endfunction

        function void report(string field, logic [63:0] want, logic [63:0] got);
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
            end
        endfunction

        function void check_outcome(queue_outcome_t got);
            queue_outcome_t want;
            if (pending_outcomes.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result item 0x%0h with nothing pending", $time, got);
            end else begin
                want = pending_outcomes.pop_front();
                checked++;
                if (got.head_valid !== want.head_valid)
                    report("head_valid", want.head_valid, got.head_valid);
                if (got.key !== want.key) report("key_out", want.key, got.key);
                if (got.tag !== want.tag) report("tag_out", want.tag, got.tag);
                if (got.occupancy !== want.occupancy)
                    report("occupancy", want.occupancy, got.occupancy);
                if (got.dropped !== want.dropped) report("dropped", want.dropped, got.dropped);
            end
        endfunction
    endclass

    logic                          aclk = 1'b0;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic                          s_mode;
    logic [speq_pkg::KEY_BITS-1:0] s_key_in;
    logic [speq_pkg::TAG_BITS-1:0] s_tag_in;
    logic                          m_valid;
    logic                          m_ready;
    logic                          m_head_valid;
    logic [speq_pkg::KEY_BITS-1:0] m_key_out;
    logic [speq_pkg::TAG_BITS-1:0] m_tag_out;
    logic [speq_pkg::CNT_BITS-1:0] m_occupancy;
    logic                          m_dropped;

    queue_order_tracker tracker;
    logic calm = 1'b0;
    int   cycle_count = 0;

    sorted_priority_event_queue_core uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_key_in     (s_key_in),
        .s_tag_in     (s_tag_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_head_valid (m_head_valid),
        .m_key_out    (m_key_out),
        .m_tag_out    (m_tag_out),
        .m_occupancy  (m_occupancy),
        .m_dropped    (m_dropped)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run stopped at the cycle limit", $time);
            $display("FAILURE");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_ready <= aresetn && (calm || $urandom_range(0, 99) >= 32);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            tracker.check_outcome({m_head_valid, m_key_out, m_tag_out, m_occupancy, m_dropped});
        end
    end

    task automatic send_op(input logic mode, input logic [speq_pkg::KEY_BITS-1:0] key,
                           input logic [speq_pkg::TAG_BITS-1:0] tag);
        if (!calm && $urandom_range(0, 99) < 32) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_valid  <= 1'b1;
        s_mode   <= mode;
        s_key_in <= key;
        s_tag_in <= tag;
        do @(posedge aclk); while (!s_ready);
        tracker.note_operation(mode, key, tag);
        @(negedge aclk);
    endtask

    task automatic hold_until_drained();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (tracker.pending_outcomes.size() != 0) @(negedge aclk);
    endtask

    // Small keys and keys already held make ties frequent; the rest span the full range.
    function automatic logic [speq_pkg::KEY_BITS-1:0] pick_key();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 30) return speq_pkg::KEY_BITS'($urandom_range(0, 15));
        if (roll < 45 && tracker.held_keys.size() != 0)
            return tracker.held_keys[$urandom_range(0, tracker.held_keys.size() - 1)];
        if (roll < 50) return ($urandom_range(0, 1) != 0) ? '1 : '0;
        return speq_pkg::KEY_BITS'($urandom);
    endfunction

    initial begin
        int          issued;
        int          span;
        int          push_pct;
        phase_kind_t kind;
        tracker  = new();
        aresetn  = 1'b0;
        s_valid  = 1'b0;
        s_mode   = speq_pkg::MODE_ENQUEUE;
        s_key_in = '0;
        s_tag_in = '0;
        m_ready  = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_op(speq_pkg::MODE_DEQUEUE, '1, '1);
        send_op(speq_pkg::MODE_ENQUEUE, 32'd5, 16'h0001);
        send_op(speq_pkg::MODE_ENQUEUE, 32'd5, 16'h0002);
        send_op(speq_pkg::MODE_ENQUEUE, 32'd9, 16'h0003);
        send_op(speq_pkg::MODE_ENQUEUE, 32'd9, 16'h0004);
        send_op(speq_pkg::MODE_ENQUEUE, '0, '0);
        send_op(speq_pkg::MODE_ENQUEUE, '1, '1);
        send_op(speq_pkg::MODE_ENQUEUE, '1, 16'hAAAA);
        send_op(speq_pkg::MODE_ENQUEUE, 32'd7, 16'h5555);
        repeat (9) send_op(speq_pkg::MODE_DEQUEUE, '0, '0);
        hold_until_drained();

        issued = 0;
        while (issued < RANDOM_ITEMS) begin
            kind = phase_kind_t'($urandom_range(0, 2));
            span = $urandom_range(20, 60);
            calm = (issued >= 450 && issued < 700);
            push_pct = (kind == FILL_BIAS) ? 85 : (kind == DRAIN_BIAS) ? 15 : 50;
            for (int n = 0; n < span && issued < RANDOM_ITEMS; n++) begin
                if ($urandom_range(0, 99) < push_pct)
                    send_op(speq_pkg::MODE_ENQUEUE, pick_key(),
                            speq_pkg::TAG_BITS'($urandom_range(0, 65535)));
                else
                    send_op(speq_pkg::MODE_DEQUEUE, speq_pkg::KEY_BITS'($urandom),
                            speq_pkg::TAG_BITS'($urandom_range(0, 65535)));
                issued++;
            end
            if ($urandom_range(0, 3) == 0) hold_until_drained();
        end
        calm = 1'b0;
        s_valid <= 1'b0;
        while (tracker.pending_outcomes.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);

        $display("Ran %0d enqueues (%0d refused on a full queue) and %0d dequeues (%0d on empty).",
                 tracker.pushes, tracker.refused, tracker.pops, tracker.empty_pops);
        $display("Checked %0d result items, peak occupancy %0d, %0d mismatches.",
                 tracker.checked, tracker.peak, tracker.mismatches);
        if (tracker.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: sorted_priority_event_queue_core.f
hw/rtl/speq_pkg.sv
hw/rtl/speq_ctrl.sv
hw/rtl/speq_datapath.sv
hw/rtl/sorted_priority_event_queue_core.sv
hw/rtl/speq_checker.sv
dv/sorted_priority_event_queue_core_tb.sv
